@@ design/assert_macros.svh @@
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Whenever ante holds, cons must hold later, after the delay given by argument n.
`define ASSERT_AFTER(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("delayed assertion failed");

`endif

@@ design/mdc_pkg.sv @@
package mdc_pkg;

  // Fraction bits of the mantissa log2, one squaring stage per bit.
  localparam int MDC_FRAC_BITS = 16;
  // Clock edges from the accepting edge to the edge that takes the result.
  localparam int MDC_LATENCY = MDC_FRAC_BITS + 5;

  localparam logic [31:0] FLOOR_BITS     = 32'h3586_37BD;
  localparam logic [24:0] LOG2_FLOOR_Q16 = 25'd1306235;
  localparam logic [24:0] EXP_BIAS_Q16   = 25'd8323072;
  localparam logic [14:0] DB_GAIN_Q16    = 15'd22547;
  localparam logic [15:0] LEVEL_MAX      = 16'd32768;
  localparam logic [7:0]  GRAY_RG        = 8'd20;
  localparam logic [7:0]  GRAY_B         = 8'd23;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } mdc_rgb_t;

  // Payload carried through the log2 squaring chain.
  typedef struct packed {
    logic [30:0]              x;
    logic [MDC_FRAC_BITS-1:0] frac;
    logic [7:0]               expo;
    logic                     missing;
  } mdc_sq_t;

  function automatic mdc_rgb_t mdc_palette(input logic [3:0] idx);
    mdc_rgb_t c;
    unique case (idx)
      4'd0:    c = '{8'd0,   8'd0,   8'd4};
      4'd1:    c = '{8'd31,  8'd12,  8'd72};
      4'd2:    c = '{8'd85,  8'd15,  8'd109};
      4'd3:    c = '{8'd136, 8'd34,  8'd106};
      4'd4:    c = '{8'd186, 8'd54,  8'd85};
      4'd5:    c = '{8'd227, 8'd89,  8'd51};
      4'd6:    c = '{8'd249, 8'd140, 8'd10};
      4'd7:    c = '{8'd249, 8'd201, 8'd50};
      4'd8:    c = '{8'd252, 8'd255, 8'd164};
      default: c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

endpackage

@@ design/mdc_front.sv @@
module mdc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [31:0]     in_bits,
  output logic            out_valid,
  output mdc_pkg::mdc_sq_t out_data
);
  import mdc_pkg::*;

  logic    valid_r;
  mdc_sq_t data_r;
  mdc_sq_t data_nxt;
  logic [31:0] bits_c;

  always_comb begin
    bits_c = in_bits;
    // Negative values, zero, subnormals and anything below the floor use the floor.
    if (in_bits[31] || (in_bits < FLOOR_BITS)) begin
      bits_c = FLOOR_BITS;
    end
    data_nxt.missing = &in_bits[30:23];
    data_nxt.expo    = bits_c[30:23];
    data_nxt.x       = {1'b1, bits_c[22:0], 7'b0};
    data_nxt.frac    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

@@ design/mdc_sq_stage.sv @@
module mdc_sq_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  mdc_pkg::mdc_sq_t in_data,
  output logic             out_valid,
  output mdc_pkg::mdc_sq_t out_data
);
  import mdc_pkg::*;

  logic        valid_r;
  mdc_sq_t     data_r;
  mdc_sq_t     data_nxt;
  logic [61:0] prod;
  logic [31:0] sq;

  // One bit of log2(1.m): square, and if the square reaches two, halve it.
  always_comb begin
    prod     = 62'(in_data.x) * 62'(in_data.x);
    sq       = prod[61:30];
    data_nxt = in_data;
    if (sq[31]) begin
      data_nxt.x = sq[31:1];
    end else begin
      data_nxt.x = sq[30:0];
    end
    data_nxt.frac = {in_data.frac[MDC_FRAC_BITS-2:0], sq[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

@@ design/mdc_level.sv @@
module mdc_level (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  mdc_pkg::mdc_sq_t in_data,
  output logic             out_valid,
  output logic             out_missing,
  output logic [15:0]      out_level
);
  import mdc_pkg::*;

  logic        lg_valid_r;
  logic        lg_missing_r;
  logic [23:0] lg_r;
  logic [23:0] lg_nxt;
  logic [24:0] lg_sum;

  logic        lv_valid_r;
  logic        lv_missing_r;
  logic [15:0] level_r;
  logic [15:0] level_nxt;
  logic [38:0] gain_prod;
  logic [18:0] gain_t;

  // Stage one: log2 in Q.16 offset so that the floor sits at zero.
  always_comb begin
    lg_sum = {1'b0, in_data.expo, 16'b0}
           + {{(25 - MDC_FRAC_BITS){1'b0}}, in_data.frac}
           + LOG2_FLOOR_Q16;
    if (lg_sum <= EXP_BIAS_Q16) begin
      lg_nxt = '0;
    end else begin
      lg_nxt = 24'(lg_sum - EXP_BIAS_Q16);
    end
  end

  // Stage two: scale to the Q4.12 level and saturate at the top anchor.
  always_comb begin
    gain_prod = 39'(lg_r) * 39'(DB_GAIN_Q16);
    gain_t    = gain_prod[38:20];
    if (gain_t > {3'b0, LEVEL_MAX}) begin
      level_nxt = LEVEL_MAX;
    end else begin
      level_nxt = gain_t[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_valid_r <= 1'b0;
      lv_valid_r <= 1'b0;
    end else begin
      lg_valid_r <= in_valid;
      lv_valid_r <= lg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      lg_r         <= lg_nxt;
      lg_missing_r <= in_data.missing;
    end
    if (lg_valid_r) begin
      level_r      <= level_nxt;
      lv_missing_r <= lg_missing_r;
    end
  end

  assign out_valid   = lv_valid_r;
  assign out_missing = lv_missing_r;
  assign out_level   = level_r;
endmodule

@@ design/mdc_interp.sv @@
module mdc_interp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_missing,
  input  logic [15:0]       in_level,
  output logic              out_valid,
  output logic              out_missing,
  output mdc_pkg::mdc_rgb_t out_color
);
  import mdc_pkg::*;

  logic        seg_cap;
  logic [2:0]  seg;
  logic [12:0] wt_hi;
  logic [12:0] wt_lo;
  mdc_rgb_t    col_lo;
  mdc_rgb_t    col_hi;

  logic        pr_valid_r;
  logic        pr_missing_r;
  logic [20:0] pr_lo_r [3];
  logic [20:0] pr_hi_r [3];
  logic [20:0] pr_lo_nxt [3];
  logic [20:0] pr_hi_nxt [3];

  logic        out_valid_r;
  logic        out_missing_r;
  mdc_rgb_t    color_r;
  mdc_rgb_t    color_nxt;
  logic [21:0] sum_c [3];

  // Stage one: pick the segment and weight, form the six partial products.
  always_comb begin
    seg_cap = in_level[15];
    seg     = seg_cap ? 3'd7 : in_level[14:12];
    wt_hi   = seg_cap ? 13'd4096 : {1'b0, in_level[11:0]};
    wt_lo   = 13'd4096 - wt_hi;
    col_lo  = mdc_palette({1'b0, seg});
    col_hi  = mdc_palette(4'({1'b0, seg}) + 4'd1);
    pr_lo_nxt[0] = 21'(col_lo.red)   * 21'(wt_lo);
    pr_lo_nxt[1] = 21'(col_lo.green) * 21'(wt_lo);
    pr_lo_nxt[2] = 21'(col_lo.blue)  * 21'(wt_lo);
    pr_hi_nxt[0] = 21'(col_hi.red)   * 21'(wt_hi);
    pr_hi_nxt[1] = 21'(col_hi.green) * 21'(wt_hi);
    pr_hi_nxt[2] = 21'(col_hi.blue)  * 21'(wt_hi);
  end

  // Stage two: add, truncate to bytes, and substitute gray for missing samples.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = {1'b0, pr_lo_r[c]} + {1'b0, pr_hi_r[c]};
    end
    if (pr_missing_r) begin
      color_nxt = '{GRAY_RG, GRAY_RG, GRAY_B};
    end else begin
      color_nxt = '{sum_c[0][19:12], sum_c[1][19:12], sum_c[2][19:12]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pr_valid_r  <= in_valid;
      out_valid_r <= pr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      pr_lo_r      <= pr_lo_nxt;
      pr_hi_r      <= pr_hi_nxt;
      pr_missing_r <= in_missing;
    end
    if (pr_valid_r) begin
      color_r       <= color_nxt;
      out_missing_r <= pr_missing_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_missing = out_missing_r;
  assign out_color   = color_r;
endmodule

@@ design/magnitude_db_colormap_top.sv @@
// Maps one spectrogram magnitude to one inferno color on a dB scale.
// Input: raise start with an IEEE single bit pattern on in_magnitude_bits; the
// beat is taken at the clock edge where start is high and busy is low. busy
// stays low, so a new beat can be taken on every cycle.
// Output: out_valid is high for one cycle with out_red, out_green, out_blue and
// out_is_missing; the beat is taken at the edge that ends that cycle. The
// receiver cannot hold results off, and none is needed: nothing waits inside.
// Pipeline: a beat taken at one edge passes through one decode stage, sixteen
// squaring stages for the mantissa log2, two stages for the dB level and two
// for the palette blend, each registered, before it is presented. Throughput is
// one beat per cycle, set by the squaring chain, one multiplier per stage.
// NaN or infinity gives gray with out_is_missing set; values at or below the
// floor give the darkest anchor, values above +20 dB the brightest.
// Reset (synchronous, active low) drops every beat in flight; no result from
// before reset appears after it.
module magnitude_db_colormap_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_magnitude_bits,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_is_missing
);
  import mdc_pkg::*;

  logic     accept;
  logic     sq_valid [MDC_FRAC_BITS+1];
  mdc_sq_t  sq_data  [MDC_FRAC_BITS+1];
  logic     lv_valid;
  logic     lv_missing;
  logic [15:0] lv_level;
  mdc_rgb_t color;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_bits   (in_magnitude_bits),
    .out_valid (sq_valid[0]),
    .out_data  (sq_data[0])
  );

  for (genvar i = 0; i < MDC_FRAC_BITS; i++) begin : g_sq
    mdc_sq_stage u_sq (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_valid[i]),
      .in_data   (sq_data[i]),
      .out_valid (sq_valid[i+1]),
      .out_data  (sq_data[i+1])
    );
  end

  mdc_level u_level (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sq_valid[MDC_FRAC_BITS]),
    .in_data     (sq_data[MDC_FRAC_BITS]),
    .out_valid   (lv_valid),
    .out_missing (lv_missing),
    .out_level   (lv_level)
  );

  mdc_interp u_interp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (lv_valid),
    .in_missing  (lv_missing),
    .in_level    (lv_level),
    .out_valid   (out_valid),
    .out_missing (out_is_missing),
    .out_color   (color)
  );

  assign out_red   = color.red;
  assign out_green = color.green;
  assign out_blue  = color.blue;
endmodule

@@ design/mdc_check.sv @@
`include "assert_macros.svh"

module mdc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_magnitude_bits,
  input logic        out_valid,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_is_missing
);
  import mdc_pkg::*;

  // Every accepted beat gives a result after the fixed latency.
  `ASSERT_AFTER(a_result_follows, start && !busy, MDC_LATENCY, out_valid)

  // A result never appears without a beat accepted exactly one latency earlier.
  `ASSERT_IMPL(a_no_spurious, out_valid, $past(start && !busy, MDC_LATENCY))

  // The missing flag follows an all-ones exponent on the matching input.
  `ASSERT_IMPL(a_missing_flag, out_valid, out_is_missing == (&$past(in_magnitude_bits[30:23], MDC_LATENCY)))

  // Missing samples are gray.
  `ASSERT_IMPL(a_gray, out_valid && out_is_missing, out_red == GRAY_RG && out_green == GRAY_RG && out_blue == GRAY_B)

  // Finite negative inputs land on the darkest anchor.
  `ASSERT_IMPL(a_negative_dark, out_valid && !out_is_missing && $past(in_magnitude_bits[31], MDC_LATENCY), out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd4)
endmodule

bind magnitude_db_colormap_top mdc_check u_mdc_check (.*);
